// ===== src/ili_pkg.sv =====
// Package for the indexed list core: sizes, command and status codes,
// and the operation word that the control logic hands to the cell row.
// No dependencies.
package ili_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths of the transaction ports
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNTO_W  = 7;

	// Internal widths
	localparam int POS_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [VAL_W-1:0] READ_MISS = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET      = 3'd0,
		CMD_ADD_HEAD = 3'd1,
		CMD_ADD_TAIL = 3'd2,
		CMD_ADD_IDX  = 3'd3,
		CMD_DEL_IDX  = 3'd4
	} ili_cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ili_status_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [POS_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] data;
	} ili_op_t;

	// Stored word -> 32-bit read value (sign-extend or cut)
	function automatic logic [VAL_W-1:0] to_read(input logic [DATA_WIDTH-1:0] d);
		logic signed [DATA_WIDTH-1:0] s;
		s = d;
		return VAL_W'(s);
	endfunction

	// 32-bit input value -> stored word (sign-extend or cut)
	function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] s;
		s = v;
		return DATA_WIDTH'(s);
	endfunction

endpackage

// ===== src/ili_cell.sv =====
// One list slot: holds a word and takes it from itself, the lower or the
// upper neighbor, or the inserted value. Depends on ili_pkg.
module ili_cell (
	input  logic                          clk,
	input  logic [ili_pkg::POS_W-1:0]     slot,
	input  ili_pkg::ili_op_t              op,
	input  logic [ili_pkg::DATA_WIDTH-1:0] from_lo,
	input  logic [ili_pkg::DATA_WIDTH-1:0] from_hi,
	output logic [ili_pkg::DATA_WIDTH-1:0] data,
	output logic [ili_pkg::DATA_WIDTH-1:0] rd_data
);
	import ili_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  hit;

	assign hit = (slot == op.pos);

	always_comb begin
		data_d = data_q;
		if (op.ins) begin
			if (hit)
				data_d = op.data;
			else if (slot > op.pos)
				data_d = from_lo;
		end else if (op.del) begin
			if (slot >= op.pos)
				data_d = from_hi;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	// gated for the OR-reduction in the row
	assign rd_data = hit ? data_q : '0;
endmodule

// ===== src/ili_chain.sv =====
// Row of CAPACITY list cells linked to their neighbors, plus the read
// path that ORs the gated cell outputs. Depends on ili_pkg, ili_cell.
module ili_chain (
	input  logic                           clk,
	input  ili_pkg::ili_op_t               op,
	output logic [ili_pkg::DATA_WIDTH-1:0] rd_data
);
	import ili_pkg::*;

	logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] lo;
		logic [DATA_WIDTH-1:0] hi;

		if (k == 0) begin : g_first
			assign lo = '0;
		end else begin : g_mid_lo
			assign lo = cell_q[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign hi = '0;
		end else begin : g_mid_hi
			assign hi = cell_q[k+1];
		end

		ili_cell u_cell (
			.clk     (clk),
			.slot    (POS_W'(k)),
			.op      (op),
			.from_lo (lo),
			.from_hi (hi),
			.data    (cell_q[k]),
			.rd_data (cell_rd[k])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int k = 0; k < CAPACITY; k++)
			rd_data = rd_data | cell_rd[k];
	end
endmodule

// ===== src/indexed_list_insert_delete_core.sv =====
// Indexed list core: ordered list of signed words with get, insert, delete.
// Depends on ili_pkg, ili_chain (and through it ili_cell).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction:
//   cmd (get, add at head, add at tail, add at index, delete at index),
//   index and value. Output channel (out_valid/out_ready) returns one
//   result transaction per command: read_value, found, status, count_after.
//   The result is registered at the edge that accepts the command.
//   Throughput is one command per cycle when out_ready is high; list cells
//   move in that same cycle, so insert and delete cost no more than get.
//   The single output register is the only buffer: while a result waits
//   (out_valid high, out_ready low) in_ready is low; when the result is
//   taken in the same cycle a new command is accepted.
//   Reset (arst_n low) empties the list and drops any pending result.
//   Cell contents are not cleared; only positions below the count are ever
//   read, and those have always been written.
//   Status: done, index out of range (checked first), or list full; on
//   either error the list is left untouched.
module indexed_list_insert_delete_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ili_pkg::CMD_W-1:0]  cmd,
	input  logic [ili_pkg::IDX_W-1:0]  index,
	input  logic signed [ili_pkg::VAL_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ili_pkg::VAL_W-1:0] read_value,
	output logic                       found,
	output logic [ili_pkg::STAT_W-1:0] status,
	output logic [ili_pkg::CNTO_W-1:0] count_after
);
	import ili_pkg::*;

	// ---- control state ----
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;

	// ---- result register (payload, no reset) ----
	logic [VAL_W-1:0]  read_value_q;
	logic              found_q;
	ili_status_t       status_q;
	logic [CNTO_W-1:0] count_after_q;

	logic              accept;
	ili_op_t           op;
	logic [DATA_WIDTH-1:0] rd_data;

	// decode results
	logic [CMP_W-1:0]  idx_ext;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  ins_pos;
	logic              is_ins;
	logic              is_get;
	logic              is_del;
	logic              idx_in_list;
	ili_status_t       status_d;
	logic [CNT_W-1:0]  count_d;

	// Next result may enter whenever the output register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign idx_ext     = CMP_W'(index);
	assign cnt_ext     = CMP_W'(count_q);
	assign idx_in_list = (idx_ext < cnt_ext);

	always_comb begin
		is_ins  = 1'b0;
		is_get  = 1'b0;
		is_del  = 1'b0;
		ins_pos = '0;
		case (cmd)
			CMD_GET: begin
				is_get = 1'b1;
			end
			CMD_ADD_HEAD: begin
				is_ins  = 1'b1;
				ins_pos = '0;
			end
			CMD_ADD_TAIL: begin
				is_ins  = 1'b1;
				ins_pos = cnt_ext;
			end
			CMD_ADD_IDX: begin
				is_ins  = 1'b1;
				ins_pos = idx_ext;
			end
			CMD_DEL_IDX: begin
				is_del = 1'b1;
			end
			default: begin
				// unused codes: no change, status done
			end
		endcase
	end

	// Status and new count. Range is checked before full.
	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		op.ins   = 1'b0;
		op.del   = 1'b0;
		op.pos   = POS_W'(idx_ext);
		op.data  = to_store(value);
		if (is_get) begin
			if (!idx_in_list)
				status_d = ST_RANGE;
		end else if (is_ins) begin
			op.pos = POS_W'(ins_pos);
			if (ins_pos > cnt_ext) begin
				status_d = ST_RANGE;
			end else if (count_q >= CNT_W'(CAPACITY)) begin
				status_d = ST_FULL;
			end else begin
				op.ins  = accept;
				count_d = count_q + 1'b1;
			end
		end else if (is_del) begin
			if (!idx_in_list) begin
				status_d = ST_RANGE;
			end else begin
				op.del  = accept;
				count_d = count_q - 1'b1;
			end
		end
	end

	// The cell row: cells from the position upward change in the accepting cycle.
	ili_chain u_chain (
		.clk     (clk),
		.op      (op),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q       <= is_get && idx_in_list;
			read_value_q  <= (is_get && idx_in_list) ? to_read(rd_data) : READ_MISS;
			status_q      <= status_d;
			count_after_q <= CNTO_W'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign found       = found_q;
	assign status      = status_q;
	assign count_after = count_after_q;
endmodule

// ===== src/ili_checker.sv =====
// Port-level checker for the indexed list core, bound to the top level.
// Depends on ili_pkg and indexed_list_insert_delete_core.
module ili_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ili_pkg::VAL_W-1:0]  read_value,
	input logic                       found,
	input logic [ili_pkg::STAT_W-1:0] status,
	input logic [ili_pkg::CNTO_W-1:0] count_after
);
	import ili_pkg::*;

	// A stalled result holds its read value and status.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled result changed");

	// A hit is always a successful command.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_DONE)
		else $error("found with error status");

	// No hit means the miss value.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> read_value == READ_MISS)
		else $error("read value not -1 on miss");

	// Full is only reported on a list at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count_after == CNTO_W'(CAPACITY))
		else $error("full reported below capacity");
endmodule

bind indexed_list_insert_delete_core ili_checker u_ili_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_value  (read_value),
	.found       (found),
	.status      (status),
	.count_after (count_after)
);
